[sv/lsd_pkg.sv]
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LIN slave diagnostic responder.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLIER_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_ID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT_ID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_NUMBER = 3'd4;

    localparam logic [7:0]  RST_NODE_ADDRESS  = 8'h01;
    localparam logic [31:0] RST_SERIAL_NUMBER = 32'h7856_3412;

    localparam logic [7:0]  NAD_WILDCARD      = 8'h7F;
    localparam logic [15:0] SUPPLIER_WILDCARD = 16'h7FFF;
    localparam logic [15:0] FUNCTION_WILDCARD = 16'hFFFF;
    localparam logic [7:0]  SLEEP_NAD         = 8'h00;
    localparam logic [7:0]  SID_READ_BY_ID    = 8'hB2;
    localparam logic [7:0]  RSID_OFFSET       = 8'h40;
    localparam logic [7:0]  NEG_SID           = 8'h7F;
    localparam logic [7:0]  NEG_PCI           = 8'h03;
    localparam logic [7:0]  NRC_NOT_SUPPORTED = 8'h11;
    localparam logic [7:0]  FILLER            = 8'hFF;
    localparam logic [7:0]  DID_PRODUCT       = 8'h00;
    localparam logic [7:0]  DID_SERIAL        = 8'h01;
    localparam logic [7:0]  PCI_PRODUCT       = 8'h06;
    localparam logic [7:0]  PCI_SERIAL        = 8'h05;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_SLOT    = 1'b1;

    typedef struct packed {
        logic [7:0]  node_address;
        logic [15:0] supplier_code;
        logic [15:0] function_code;
        logic [7:0]  variant_id;
        logic [31:0] serial_number;
    } t_cfg;

    typedef struct packed {
        logic       pending;
        logic [7:0] service;
        logic [7:0] data_id;
    } t_diag_state;

    typedef struct packed {
        logic            response_valid;
        logic            sleep_request;
        logic [7:0][7:0] frame;
    } t_rsp;

endpackage

[sv/lsd_req_if.sv]
// ----------------------------------------------------------------------------
// lsd_req_if
// Frame event channel: master request frame or response slot.
// ----------------------------------------------------------------------------
interface lsd_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] request_byte_0;
    logic [7:0] request_byte_1;
    logic [7:0] request_byte_2;
    logic [7:0] request_byte_3;
    logic [7:0] request_byte_4;
    logic [7:0] request_byte_5;
    logic [7:0] request_byte_6;
    logic [7:0] request_byte_7;

    modport source (
        output valid, opcode, request_byte_0, request_byte_1, request_byte_2,
               request_byte_3, request_byte_4, request_byte_5, request_byte_6,
               request_byte_7,
        input  ready
    );
    modport sink (
        input  valid, opcode, request_byte_0, request_byte_1, request_byte_2,
               request_byte_3, request_byte_4, request_byte_5, request_byte_6,
               request_byte_7,
        output ready
    );
endinterface

[sv/lsd_rsp_if.sv]
// ----------------------------------------------------------------------------
// lsd_rsp_if
// Result channel: response frame and sleep flag.
// ----------------------------------------------------------------------------
interface lsd_rsp_if;
    logic       valid;
    logic       ready;
    logic       response_valid;
    logic       sleep_request;
    logic [7:0] response_byte_0;
    logic [7:0] response_byte_1;
    logic [7:0] response_byte_2;
    logic [7:0] response_byte_3;
    logic [7:0] response_byte_4;
    logic [7:0] response_byte_5;
    logic [7:0] response_byte_6;
    logic [7:0] response_byte_7;

    modport source (
        output valid, response_valid, sleep_request, response_byte_0,
               response_byte_1, response_byte_2, response_byte_3, response_byte_4,
               response_byte_5, response_byte_6, response_byte_7,
        input  ready
    );
    modport sink (
        input  valid, response_valid, sleep_request, response_byte_0,
               response_byte_1, response_byte_2, response_byte_3, response_byte_4,
               response_byte_5, response_byte_6, response_byte_7,
        output ready
    );
endinterface

[sv/lsd_cfg_if.sv]
// ----------------------------------------------------------------------------
// lsd_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface lsd_cfg_if
    import lsd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/lin_slave_diag_responder.sv]
// ----------------------------------------------------------------------------
// lin_slave_diag_responder
// Each accepted frame event's result is built combinationally and captured in the output register on acceptance.
// Throughput: one event per cycle while the output is not stalled; the output register frees in the cycle it is taken.
// Reset (sync, active low) clears the pending mark, stored SID/identifier and the
// output register, and loads the configuration reset values.
// ----------------------------------------------------------------------------
module lin_slave_diag_responder
    import lsd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsd_req_if.sink       i_req,
    lsd_cfg_if.sink       i_cfg,
    lsd_rsp_if.source     o_rsp
);

    t_cfg            cfg;
    t_diag_state     state;
    t_rsp            rsp;
    logic            is_sleep;
    logic            req_accept;
    logic [7:0][7:0] req_bytes;

    logic r_out_valid;
    t_rsp r_rsp;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_accept  = i_req.valid && i_req.ready;

    assign req_bytes = {i_req.request_byte_7, i_req.request_byte_6, i_req.request_byte_5,
                        i_req.request_byte_4, i_req.request_byte_3, i_req.request_byte_2,
                        i_req.request_byte_1, i_req.request_byte_0};

    lsd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    lsd_req_check u_req_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (req_accept),
        .i_opcode   (i_req.opcode),
        .i_bytes    (req_bytes),
        .i_cfg      (cfg),
        .o_is_sleep (is_sleep),
        .o_state    (state)
    );

    lsd_rsp_build u_rsp_build (
        .i_opcode   (i_req.opcode),
        .i_is_sleep (is_sleep),
        .i_cfg      (cfg),
        .i_state    (state),
        .o_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rsp       <= '0;
        end else begin
            if (req_accept) begin
                r_out_valid <= 1'b1;
                r_rsp       <= rsp;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.response_valid  = r_rsp.response_valid;
    assign o_rsp.sleep_request   = r_rsp.sleep_request;
    assign o_rsp.response_byte_0 = r_rsp.frame[0];
    assign o_rsp.response_byte_1 = r_rsp.frame[1];
    assign o_rsp.response_byte_2 = r_rsp.frame[2];
    assign o_rsp.response_byte_3 = r_rsp.frame[3];
    assign o_rsp.response_byte_4 = r_rsp.frame[4];
    assign o_rsp.response_byte_5 = r_rsp.frame[5];
    assign o_rsp.response_byte_6 = r_rsp.frame[6];
    assign o_rsp.response_byte_7 = r_rsp.frame[7];

endmodule

[sv/lsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lsd_cfg_regs
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lsd_cfg_regs
    import lsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_NODE_ADDRESS:  n_cfg.node_address  = i_wr_data[7:0];
                CFG_SUPPLIER_ID:   n_cfg.supplier_code = i_wr_data[15:0];
                CFG_FUNCTION_ID:   n_cfg.function_code = i_wr_data[15:0];
                CFG_VARIANT_ID:    n_cfg.variant_id    = i_wr_data[7:0];
                CFG_SERIAL_NUMBER: n_cfg.serial_number = i_wr_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_address  <= RST_NODE_ADDRESS;
            r_cfg.supplier_code <= '0;
            r_cfg.function_code <= '0;
            r_cfg.variant_id    <= '0;
            r_cfg.serial_number <= RST_SERIAL_NUMBER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/lsd_req_check.sv]
// ----------------------------------------------------------------------------
// lsd_req_check
// Request frame filter: sleep detect, address and ID match, pending state.
// ----------------------------------------------------------------------------
module lsd_req_check
    import lsd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_opcode,
    input  logic [7:0][7:0] i_bytes,
    input  t_cfg            i_cfg,
    output logic            o_is_sleep,
    output t_diag_state     o_state
);

    t_diag_state r_state;
    t_diag_state n_state;
    logic        is_sleep;
    logic        tail_ff;
    logic [15:0] sup;
    logic [15:0] fun;
    logic        id_match;

    always_comb begin
        tail_ff = 1'b1;
        for (int i = 1; i < 8; i++) begin
            if (i_bytes[i] != FILLER) begin
                tail_ff = 1'b0;
            end
        end
        is_sleep = (i_bytes[0] == SLEEP_NAD) && tail_ff;

        sup = {i_bytes[5], i_bytes[4]};
        fun = {i_bytes[7], i_bytes[6]};
        id_match = ((i_bytes[0] == i_cfg.node_address) || (i_bytes[0] == NAD_WILDCARD))
                && ((sup == i_cfg.supplier_code) || (sup == SUPPLIER_WILDCARD))
                && ((fun == i_cfg.function_code) || (fun == FUNCTION_WILDCARD));

        n_state = r_state;
        if (i_accept && (i_opcode == OP_REQUEST) && !is_sleep) begin
            n_state.pending = id_match;
            if (id_match) begin
                n_state.service = i_bytes[2];
                n_state.data_id = i_bytes[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_is_sleep = is_sleep;
    assign o_state    = r_state;

endmodule

[sv/lsd_rsp_build.sv]
// ----------------------------------------------------------------------------
// lsd_rsp_build
// Response frame builder for a slot or the request acknowledge result.
// ----------------------------------------------------------------------------
module lsd_rsp_build
    import lsd_pkg::*;
(
    input  logic        i_opcode,
    input  logic        i_is_sleep,
    input  t_cfg        i_cfg,
    input  t_diag_state i_state,
    output t_rsp        o_rsp
);

    logic is_rbi;

    always_comb begin
        is_rbi = (i_state.service == SID_READ_BY_ID);
        o_rsp  = '0;
        if (i_opcode == OP_REQUEST) begin
            o_rsp.sleep_request = i_is_sleep;
        end else if (i_state.pending) begin
            o_rsp.response_valid = 1'b1;
            o_rsp.frame[0] = i_cfg.node_address;
            if (is_rbi && (i_state.data_id == DID_PRODUCT)) begin
                o_rsp.frame[1] = PCI_PRODUCT;
                o_rsp.frame[2] = SID_READ_BY_ID | RSID_OFFSET;
                o_rsp.frame[3] = i_cfg.supplier_code[7:0];
                o_rsp.frame[4] = i_cfg.supplier_code[15:8];
                o_rsp.frame[5] = i_cfg.function_code[7:0];
                o_rsp.frame[6] = i_cfg.function_code[15:8];
                o_rsp.frame[7] = i_cfg.variant_id;
            end else if (is_rbi && (i_state.data_id == DID_SERIAL)) begin
                o_rsp.frame[1] = PCI_SERIAL;
                o_rsp.frame[2] = SID_READ_BY_ID | RSID_OFFSET;
                o_rsp.frame[3] = i_cfg.serial_number[7:0];
                o_rsp.frame[4] = i_cfg.serial_number[15:8];
                o_rsp.frame[5] = i_cfg.serial_number[23:16];
                o_rsp.frame[6] = i_cfg.serial_number[31:24];
                o_rsp.frame[7] = FILLER;
            end else begin
                // negative response: service not supported
                o_rsp.frame[1] = NEG_PCI;
                o_rsp.frame[2] = NEG_SID;
                o_rsp.frame[3] = i_state.service;
                o_rsp.frame[4] = NRC_NOT_SUPPORTED;
                o_rsp.frame[5] = FILLER;
                o_rsp.frame[6] = FILLER;
                o_rsp.frame[7] = FILLER;
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LIN slave diagnostic responder: master request
// frames and response slots are driven through the request channel, an
// in-bench predictor tracks the pending mark and the node settings, and every
// result taken from the output channel is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import lsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 65;
    localparam int unsigned MAX_REPORTS     = 40;

    localparam logic [7:0] SLEEP_PAD       = 8'hFF;
    localparam logic [7:0] SID_UNSUPPORTED = 8'h22;
    localparam logic [7:0] DID_UNKNOWN     = 8'h02;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE = 3'd7;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef enum logic [2:0] {
        RQ_MATCH, RQ_BAD_NAD, RQ_BAD_SUPPLIER, RQ_BAD_FUNCTION,
        RQ_SLEEP, RQ_NEAR_SLEEP, RQ_NOISE
    } t_req_kind;

    typedef struct packed {
        logic            opcode;
        logic [7:0][7:0] rq;
    } t_frame_event;

    logic clk;
    logic rst_n;

    lsd_req_if req_if ();
    lsd_cfg_if cfg_if ();
    lsd_rsp_if rsp_if ();

    lin_slave_diag_responder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    // predictor state
    t_cfg        node_cfg;
    t_diag_state diag_state;
    t_rsp        expected_rsp_q[$];

    int unsigned mismatch_count  = 0;
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned responses_seen  = 0;
    int unsigned sleeps_seen     = 0;
    int unsigned reg_writes      = 0;

    // traffic shaping
    int unsigned burst_left    = 0;
    int unsigned gap_max       = 0;
    int unsigned rsp_hold_left = 0;
    t_rx_mode    rx_mode       = RX_ALWAYS;
    logic [7:0]  rx_pattern    = 8'hFF;
    logic [2:0]  rx_phase      = '0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d results still outstanding", $time,
                 expected_rsp_q.size());
        $display("** lin_slave_diag_responder: FAILED **");
        $finish;
    end

    // result ready: long hold-off first, otherwise the current stall mode
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_hold_left > 0) begin
                rsp_hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: rsp_if.ready <= 1'b1;
                    RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 99) >= 35);
                    default: begin
                        rsp_if.ready <= rx_pattern[rx_phase];
                        rx_phase <= rx_phase + 3'd1;
                    end
                endcase
            end
        end
    end

    function automatic t_rsp predict_frame_event(t_frame_event ev);
        t_rsp        r;
        logic        is_sleep;
        logic [15:0] sup;
        logic [15:0] fun;
        int          i;
        r = '0;
        if (ev.opcode == OP_REQUEST) begin
            is_sleep = (ev.rq[0] == SLEEP_NAD);
            for (i = 1; i < 8; i++) begin
                if (ev.rq[i] != SLEEP_PAD) is_sleep = 1'b0;
            end
            sup = {ev.rq[5], ev.rq[4]};
            fun = {ev.rq[7], ev.rq[6]};
            if (is_sleep) begin
                // go-to-sleep leaves the pending mark alone
                r.sleep_request = 1'b1;
            end else if ((ev.rq[0] == node_cfg.node_address || ev.rq[0] == NAD_WILDCARD) &&
                         (sup == node_cfg.supplier_code || sup == SUPPLIER_WILDCARD) &&
                         (fun == node_cfg.function_code || fun == FUNCTION_WILDCARD)) begin
                diag_state.pending = 1'b1;
                diag_state.service = ev.rq[2];
                diag_state.data_id = ev.rq[3];
            end else begin
                diag_state.pending = 1'b0;
            end
        end else if (diag_state.pending) begin
            r.response_valid = 1'b1;
            r.frame[0] = node_cfg.node_address;
            for (i = 3; i < 8; i++) r.frame[i] = FILLER;
            if (diag_state.service == SID_READ_BY_ID && diag_state.data_id == DID_PRODUCT) begin
                r.frame[1] = PCI_PRODUCT;
                r.frame[2] = SID_READ_BY_ID | RSID_OFFSET;
                r.frame[3] = node_cfg.supplier_code[7:0];
                r.frame[4] = node_cfg.supplier_code[15:8];
                r.frame[5] = node_cfg.function_code[7:0];
                r.frame[6] = node_cfg.function_code[15:8];
                r.frame[7] = node_cfg.variant_id;
            end else if (diag_state.service == SID_READ_BY_ID &&
                         diag_state.data_id == DID_SERIAL) begin
                r.frame[1] = PCI_SERIAL;
                r.frame[2] = SID_READ_BY_ID | RSID_OFFSET;
                r.frame[3] = node_cfg.serial_number[7:0];
                r.frame[4] = node_cfg.serial_number[15:8];
                r.frame[5] = node_cfg.serial_number[23:16];
                r.frame[6] = node_cfg.serial_number[31:24];
            end else begin
                r.frame[1] = NEG_PCI;
                r.frame[2] = NEG_SID;
                r.frame[3] = diag_state.service;
                r.frame[4] = NRC_NOT_SUPPORTED;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_rsp            want;
        logic [7:0][7:0] got;
        int              k;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_rsp_q.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual %0b/%0b",
                             $time, rsp_if.response_valid, rsp_if.sleep_request);
                mismatch_count++;
            end else begin
                want = expected_rsp_q.pop_front();
                got = {rsp_if.response_byte_7, rsp_if.response_byte_6,
                       rsp_if.response_byte_5, rsp_if.response_byte_4,
                       rsp_if.response_byte_3, rsp_if.response_byte_2,
                       rsp_if.response_byte_1, rsp_if.response_byte_0};
                check_field("response_valid", 8'(want.response_valid),
                            8'(rsp_if.response_valid));
                check_field("sleep_request", 8'(want.sleep_request),
                            8'(rsp_if.sleep_request));
                for (k = 0; k < 8; k++)
                    check_field($sformatf("response_byte_%0d", k), want.frame[k], got[k]);
                results_checked++;
                if (want.response_valid) responses_seen++;
                if (want.sleep_request) sleeps_seen++;
            end
        end
    end

    // one request over the frame event channel, with bursty gaps
    task automatic send_request(t_frame_event ev);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_if.valid          <= 1'b1;
        req_if.opcode         <= ev.opcode;
        req_if.request_byte_0 <= ev.rq[0];
        req_if.request_byte_1 <= ev.rq[1];
        req_if.request_byte_2 <= ev.rq[2];
        req_if.request_byte_3 <= ev.rq[3];
        req_if.request_byte_4 <= ev.rq[4];
        req_if.request_byte_5 <= ev.rq[5];
        req_if.request_byte_6 <= ev.rq[6];
        req_if.request_byte_7 <= ev.rq[7];
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        expected_rsp_q.push_back(predict_frame_event(ev));
        burst_left--;
        requests_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        case (idx)
            CFG_NODE_ADDRESS:  node_cfg.node_address  = data[7:0];
            CFG_SUPPLIER_ID:   node_cfg.supplier_code = data[15:0];
            CFG_FUNCTION_ID:   node_cfg.function_code = data[15:0];
            CFG_VARIANT_ID:    node_cfg.variant_id    = data[7:0];
            CFG_SERIAL_NUMBER: node_cfg.serial_number = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    // narrow registers get junk in the unused upper bits; spare indexes must be ignored
    task automatic configure(t_cfg c);
        logic [31:0] noise;
        int          s;
        noise = $urandom;
        write_reg(CFG_NODE_ADDRESS, {noise[31:8], c.node_address});
        write_reg(CFG_SUPPLIER_ID, {noise[31:16], c.supplier_code});
        write_reg(CFG_FUNCTION_ID, {noise[15:0], c.function_code});
        write_reg(CFG_VARIANT_ID, {noise[23:0], c.variant_id});
        write_reg(CFG_SERIAL_NUMBER, c.serial_number);
        for (s = int'(CFG_SERIAL_NUMBER) + 1; s <= int'(CFG_LAST_SPARE); s++)
            write_reg(s[CFG_IDX_W-1:0], $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    function automatic t_frame_event master_frame_of(logic [7:0] nad, logic [7:0] pci,
                                                     logic [7:0] sid, logic [7:0] did,
                                                     logic [15:0] sup, logic [15:0] fun);
        t_frame_event ev;
        ev.opcode = OP_REQUEST;
        ev.rq = {fun[15:8], fun[7:0], sup[15:8], sup[7:0], did, sid, pci, nad};
        return ev;
    endfunction

    function automatic t_frame_event make_slot();
        t_frame_event ev;
        ev.opcode = OP_SLOT;
        ev.rq = {$urandom, $urandom};
        return ev;
    endfunction

    function automatic t_frame_event make_master_frame(t_req_kind kind);
        t_frame_event ev;
        logic [7:0]   nad;
        logic [15:0]  sup;
        logic [15:0]  fun;
        int unsigned  pos;
        int           i;
        ev.opcode = OP_REQUEST;
        ev.rq = {$urandom, $urandom};
        nad = ($urandom_range(0, 3) == 0) ? NAD_WILDCARD : node_cfg.node_address;
        sup = ($urandom_range(0, 3) == 0) ? SUPPLIER_WILDCARD : node_cfg.supplier_code;
        fun = ($urandom_range(0, 3) == 0) ? FUNCTION_WILDCARD : node_cfg.function_code;
        ev.rq[2] = ($urandom_range(0, 9) < 7) ? SID_READ_BY_ID : 8'($urandom);
        pos = $urandom_range(0, 19);
        ev.rq[3] = (pos < 8) ? DID_PRODUCT : (pos < 15) ? DID_SERIAL : 8'($urandom);
        case (kind)
            RQ_BAD_NAD: begin
                do nad = 8'($urandom);
                while (nad == node_cfg.node_address || nad == NAD_WILDCARD);
            end
            RQ_BAD_SUPPLIER: begin
                do sup = 16'($urandom);
                while (sup == node_cfg.supplier_code || sup == SUPPLIER_WILDCARD);
            end
            RQ_BAD_FUNCTION: begin
                do fun = 16'($urandom);
                while (fun == node_cfg.function_code || fun == FUNCTION_WILDCARD);
            end
            default: ;
        endcase
        ev.rq[0] = nad;
        ev.rq[4] = sup[7:0];
        ev.rq[5] = sup[15:8];
        ev.rq[6] = fun[7:0];
        ev.rq[7] = fun[15:8];
        if (kind == RQ_NOISE) ev.rq = {$urandom, $urandom};
        if (kind == RQ_SLEEP || kind == RQ_NEAR_SLEEP) begin
            ev.rq[0] = SLEEP_NAD;
            for (i = 1; i < 8; i++) ev.rq[i] = SLEEP_PAD;
            if (kind == RQ_NEAR_SLEEP) begin
                // one flipped bit anywhere breaks the sleep pattern
                pos = $urandom_range(0, 63);
                ev.rq[pos / 8][pos % 8] = ~ev.rq[pos / 8][pos % 8];
            end
        end
        return ev;
    endfunction

    // a master request followed by a few slots; now and then stray slots only
    task automatic random_exchange();
        int unsigned pick;
        int unsigned nslots;
        t_req_kind   kind;
        pick = $urandom_range(0, 99);
        if (pick < 55)      kind = RQ_MATCH;
        else if (pick < 65) kind = RQ_BAD_NAD;
        else if (pick < 72) kind = RQ_BAD_SUPPLIER;
        else if (pick < 79) kind = RQ_BAD_FUNCTION;
        else if (pick < 85) kind = RQ_SLEEP;
        else if (pick < 91) kind = RQ_NEAR_SLEEP;
        else                kind = RQ_NOISE;
        if ($urandom_range(0, 19) != 0) send_request(make_master_frame(kind));
        nslots = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
        repeat (nslots) send_request(make_slot());
    endtask

    task automatic test_reset_state();
        rx_mode = RX_RANDOM;
        gap_max = 3;
        send_request(make_slot());
        send_request(master_frame_of(RST_NODE_ADDRESS, PCI_PRODUCT, SID_READ_BY_ID,
                                     DID_PRODUCT, 16'h0000, 16'h0000));
        send_request(make_slot());
        send_request(master_frame_of(NAD_WILDCARD, PCI_PRODUCT, SID_READ_BY_ID, DID_SERIAL,
                                     SUPPLIER_WILDCARD, FUNCTION_WILDCARD));
        send_request(make_slot());
        // mark stays set, so the same answer comes again
        send_request(make_slot());
    endtask

    task automatic test_extreme_settings();
        t_cfg c;
        wait_drained();
        c = '1;
        configure(c);
        rx_mode = RX_PATTERN;
        rx_pattern = 8'b1011_0110;
        send_request(master_frame_of(8'hFF, 8'hFF, SID_READ_BY_ID, DID_PRODUCT,
                                     16'hFFFF, 16'hFFFF));
        send_request(make_slot());
        send_request(make_master_frame(RQ_SLEEP));
        send_request(make_slot());
        send_request(master_frame_of(SLEEP_NAD, SLEEP_PAD, SLEEP_PAD, SLEEP_PAD,
                                     16'hFFFF, 16'hFEFF));
        send_request(make_slot());
        send_request(master_frame_of(8'hFF, 8'h00, SID_UNSUPPORTED, DID_SERIAL,
                                     16'hFFFF, 16'hFFFF));
        send_request(make_slot());
        send_request(master_frame_of(8'hFF, 8'h00, SID_READ_BY_ID, DID_UNKNOWN,
                                     16'hFFFF, 16'hFFFF));
        send_request(make_slot());
        send_request(master_frame_of(8'hFF, PCI_SERIAL, SID_READ_BY_ID, DID_SERIAL,
                                     16'h1234, 16'hFFFF));
        send_request(make_slot());
        wait_drained();
        c = '0;
        configure(c);
        // own address 00 must not shadow the sleep pattern
        send_request(make_master_frame(RQ_SLEEP));
        send_request(master_frame_of(8'h00, 8'h00, SID_READ_BY_ID, DID_SERIAL,
                                     16'h0000, 16'h0000));
        send_request(make_slot());
        send_request(master_frame_of(8'h00, 8'h00, SID_READ_BY_ID, DID_PRODUCT,
                                     16'h0000, 16'h0001));
        send_request(make_slot());
    endtask

    task automatic test_random_traffic();
        t_cfg        c;
        int unsigned phase;
        int unsigned start;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            c = t_cfg'(80'({$urandom, $urandom, $urandom}));
            case (phase)
                0: begin
                    c.node_address  = NAD_WILDCARD;
                    c.supplier_code = SUPPLIER_WILDCARD;
                    c.function_code = FUNCTION_WILDCARD;
                end
                1: c.node_address = 8'h00;
                2: c.node_address = 8'hFF;
                default: ;
            endcase
            wait_drained();
            configure(c);
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_pattern = 8'($urandom_range(1, 255));
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            start = requests_sent;
            while (requests_sent - start < ITEMS_PER_PHASE) random_exchange();
        end
    endtask

    task automatic test_output_backpressure();
        int unsigned start;
        wait_drained();
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        rsp_hold_left = HOLD_OFF_CYCLES;
        start = requests_sent;
        while (requests_sent - start < 20) random_exchange();
        rx_mode = RX_RANDOM;
    endtask

    initial begin
        rst_n                 <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.opcode         <= OP_REQUEST;
        req_if.request_byte_0 <= '0;
        req_if.request_byte_1 <= '0;
        req_if.request_byte_2 <= '0;
        req_if.request_byte_3 <= '0;
        req_if.request_byte_4 <= '0;
        req_if.request_byte_5 <= '0;
        req_if.request_byte_6 <= '0;
        req_if.request_byte_7 <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= CFG_NODE_ADDRESS;
        cfg_if.data           <= '0;

        node_cfg               = '0;
        node_cfg.node_address  = RST_NODE_ADDRESS;
        node_cfg.serial_number = RST_SERIAL_NUMBER;
        diag_state             = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_extreme_settings();
        test_random_traffic();
        test_output_backpressure();
        wait_drained();

        $display("Run covered %0d frame events and %0d register writes over %0d settings.",
                 requests_sent, reg_writes, RANDOM_PHASES + 3);
        $display("Checked %0d results: %0d responses, %0d sleep commands, %0d mismatches.",
                 results_checked, responses_seen, sleeps_seen, mismatch_count);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
            $display("** lin_slave_diag_responder: PASSED **");
        end else begin
            $display("** lin_slave_diag_responder: FAILED **");
        end
        $finish;
    end

endmodule
